/* rtl/quick_sort_engine_defines.svh */
// Assertion macros shared by the quick sort engine RTL.
`ifndef QUICK_SORT_ENGINE_DEFINES_SVH
`define QUICK_SORT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define QSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define QSE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define QSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define QSE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/qse_pkg.sv */
`default_nettype none

package qse_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Commands from the sort sequencer to the range stack.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

`default_nettype wire

/* rtl/qse_range_stack.sv */
`default_nettype none

module qse_range_stack #(
  parameter int DEPTH = 17,
  parameter int IDXW  = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  qse_pkg::stk_cmd_t    cmd_i,
  input  wire  [IDXW-1:0]      push_lo_i,
  input  wire  [IDXW-1:0]      push_hi_i,
  output logic [IDXW-1:0]      pop_lo_o,
  output logic [IDXW-1:0]      pop_hi_o,
  output logic                 empty_o
);
  import qse_pkg::*;

  `include "quick_sort_engine_defines.svh"

  localparam int SPW = $clog2(DEPTH + 1);
  localparam int AW  = $clog2(DEPTH);

  logic [2*IDXW-1:0] stk_mem [DEPTH];
  logic [2*IDXW-1:0] rd_q;
  logic [SPW-1:0]    sp_q, sp_d;
  logic [SPW-1:0]    sp_m1;
  logic              wr_en;

  assign sp_m1 = sp_q - SPW'(1);

  // A push onto a full stack is dropped.
  always_comb begin
    sp_d  = sp_q;
    wr_en = 1'b0;
    if (cmd_i.push && (sp_q < SPW'(DEPTH))) begin
      wr_en = 1'b1;
      sp_d  = sp_q + SPW'(1);
    end else if (cmd_i.pop && (sp_q != '0)) begin
      sp_d = sp_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stk_mem[sp_q[AW-1:0]] <= {push_lo_i, push_hi_i};
    end
    if (cmd_i.pop) begin
      rd_q <= stk_mem[sp_m1[AW-1:0]];
    end
  end

  assign pop_lo_o = rd_q[2*IDXW-1:IDXW];
  assign pop_hi_o = rd_q[IDXW-1:0];
  assign empty_o  = (sp_q == '0);

  `QSE_ASSERT_NEVER(a_push_and_pop, clk_i, rst_ni, cmd_i.push && cmd_i.pop, "range stack push and pop in one cycle")
  `QSE_ASSERT(a_pop_not_empty, clk_i, rst_ni, cmd_i.pop |-> !empty_o, "range stack popped while empty")

endmodule

`default_nettype wire

/* rtl/qse_out_stage.sv */
`default_nettype none

module qse_out_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  qse_pkg::value_t     value_i,
  input  wire                 last_i,
  input  wire                 ready_i,
  output logic                valid_o,
  output qse_pkg::value_t     value_o,
  output logic                last_o
);
  import qse_pkg::*;

  `include "quick_sort_engine_defines.svh"

  logic   valid_q;
  value_t value_q;
  logic   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign last_o  = last_q;

  `QSE_ASSERT(a_load_when_free, clk_i, rst_ni, load_i |-> !valid_q, "result register loaded while occupied")

endmodule

`default_nettype wire

/* rtl/quick_sort_engine.sv */
// Channel | Signals                                    | Transfer when
// --------+--------------------------------------------+---------------------------
// in      | in_valid_i, in_ready_o, value_i, last_i    | in_valid_i && in_ready_o
// out     | out_valid_o, out_ready_i, sorted_value_o,  | out_valid_o && out_ready_i
//         | last_res_o                                 |
//
// Loading stores input values up to capacity in the element memory. The sort then runs a
// start step, then per range a pop, a pivot read, a scan that swaps each element below the
// pivot down, a pivot move and the part pushes, and a final pop step that finds the stack
// empty. Each result is read only after the previous one has left the result register.
// Reset is asynchronous and clears only control state; memories are not cleared.
// The input is not ready during sorting and result emission.
`default_nettype none

module quick_sort_engine #(
  parameter int CAPACITY = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  qse_pkg::value_t  value_i,
  input  wire              last_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output qse_pkg::value_t  sorted_value_o,
  output logic             last_res_o
);
  import qse_pkg::*;

  `include "quick_sort_engine_defines.svh"

  localparam int IDXW  = $clog2(CAPACITY);
  localparam int CNTW  = $clog2(CAPACITY + 1);
  localparam int DEPTH = CAPACITY + 1;

  // One-hot sequencer states.
  typedef enum logic [13:0] {
    ST_LOAD  = 14'h0001,
    ST_INIT  = 14'h0002,
    ST_POP   = 14'h0004,
    ST_POPW  = 14'h0008,
    ST_PIV   = 14'h0010,
    ST_CMP   = 14'h0020,
    ST_SWR   = 14'h0040,
    ST_SW2   = 14'h0080,
    ST_FRD   = 14'h0100,
    ST_FW1   = 14'h0200,
    ST_FW2   = 14'h0400,
    ST_PUSH2 = 14'h0800,
    ST_ORD   = 14'h1000,
    ST_OLD   = 14'h2000
  } state_e;

  state_e          state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [IDXW-1:0] lo_q, lo_d;
  logic [IDXW-1:0] hi_q, hi_d;
  logic [IDXW-1:0] k_q, k_d;
  logic [IDXW-1:0] m_q, m_d;
  logic [IDXW-1:0] oidx_q, oidx_d;
  value_t          pivot_q, pivot_d;
  value_t          vk_q, vk_d;
  value_t          tmp_q, tmp_d;

  // Element memory: one write port and one registered read port.
  value_t          elem_mem [CAPACITY];
  value_t          rdata_q;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  value_t          mem_wdata;
  logic            mem_re;
  logic [IDXW-1:0] mem_raddr;

  // Range stack interface.
  stk_cmd_t        stk_cmd;
  logic [IDXW-1:0] stk_push_lo;
  logic [IDXW-1:0] stk_push_hi;
  logic [IDXW-1:0] stk_pop_lo;
  logic [IDXW-1:0] stk_pop_hi;
  logic            stk_empty;

  // Result register interface.
  logic            out_load;
  logic            out_last;

  logic            in_xfer;
  logic [IDXW:0]   m_plus1_w;
  logic [IDXW:0]   lo_plus1_w;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign m_plus1_w  = {1'b0, m_q} + (IDXW+1)'(1);
  assign lo_plus1_w = {1'b0, lo_q} + (IDXW+1)'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    m_d         = m_q;
    oidx_d      = oidx_q;
    pivot_d     = pivot_q;
    vk_d        = vk_q;
    tmp_d       = tmp_q;
    mem_we      = 1'b0;
    mem_waddr   = k_q;
    mem_wdata   = tmp_q;
    mem_re      = 1'b0;
    mem_raddr   = k_q;
    stk_cmd     = '0;
    stk_push_lo = lo_q;
    stk_push_hi = hi_q;
    out_load    = 1'b0;
    out_last    = 1'b0;

    case (state_q)
      ST_LOAD: begin
        // Values beyond capacity are dropped, but a last marker still starts the sort.
        if (in_xfer) begin
          if (count_q < CNTW'(CAPACITY)) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IDXW-1:0];
            mem_wdata = value_i;
            count_d   = count_q + CNTW'(1);
          end
          if (last_i) begin
            state_d = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        // The whole set is the first range, unless it has a single element.
        if (count_q >= CNTW'(2)) begin
          stk_cmd.push = 1'b1;
          stk_push_lo  = '0;
          stk_push_hi  = IDXW'(count_q - CNTW'(1));
        end
        state_d = ST_POP;
      end

      ST_POP: begin
        if (stk_empty) begin
          oidx_d  = '0;
          state_d = ST_ORD;
        end else begin
          stk_cmd.pop = 1'b1;
          state_d     = ST_POPW;
        end
      end

      ST_POPW: begin
        lo_d      = stk_pop_lo;
        hi_d      = stk_pop_hi;
        mem_re    = 1'b1;
        mem_raddr = stk_pop_lo;
        state_d   = ST_PIV;
      end

      ST_PIV: begin
        // The first element of the range is the pivot; the scan starts right after it.
        pivot_d   = rdata_q;
        m_d       = lo_q;
        k_d       = lo_q + IDXW'(1);
        mem_re    = 1'b1;
        mem_raddr = lo_q + IDXW'(1);
        state_d   = ST_CMP;
      end

      ST_CMP: begin
        if (rdata_q < pivot_q) begin
          // Fetch the element just past the boundary to swap it with this one.
          vk_d      = rdata_q;
          mem_re    = 1'b1;
          mem_raddr = m_q + IDXW'(1);
          state_d   = ST_SWR;
        end else if (k_q == hi_q) begin
          state_d = ST_FRD;
        end else begin
          k_d       = k_q + IDXW'(1);
          mem_re    = 1'b1;
          mem_raddr = k_q + IDXW'(1);
        end
      end

      ST_SWR: begin
        mem_we    = 1'b1;
        mem_waddr = m_q + IDXW'(1);
        mem_wdata = vk_q;
        tmp_d     = rdata_q;
        m_d       = m_q + IDXW'(1);
        state_d   = ST_SW2;
      end

      ST_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = tmp_q;
        if (k_q == hi_q) begin
          state_d = ST_FRD;
        end else begin
          k_d       = k_q + IDXW'(1);
          mem_re    = 1'b1;
          mem_raddr = k_q + IDXW'(1);
          state_d   = ST_CMP;
        end
      end

      ST_FRD: begin
        // The pivot goes to the boundary; the pivot slot was never touched by the scan.
        mem_re    = 1'b1;
        mem_raddr = m_q;
        state_d   = ST_FW1;
      end

      ST_FW1: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = rdata_q;
        state_d   = ST_FW2;
      end

      ST_FW2: begin
        mem_we    = 1'b1;
        mem_waddr = m_q;
        mem_wdata = pivot_q;
        // The upper part is pushed first so that the lower part is sorted first.
        if (m_plus1_w < {1'b0, hi_q}) begin
          stk_cmd.push = 1'b1;
          stk_push_lo  = m_plus1_w[IDXW-1:0];
          stk_push_hi  = hi_q;
        end
        state_d = ST_PUSH2;
      end

      ST_PUSH2: begin
        if (lo_plus1_w < {1'b0, m_q}) begin
          stk_cmd.push = 1'b1;
          stk_push_lo  = lo_q;
          stk_push_hi  = m_q - IDXW'(1);
        end
        state_d = ST_POP;
      end

      ST_ORD: begin
        if (!out_valid_o) begin
          mem_re    = 1'b1;
          mem_raddr = oidx_q;
          state_d   = ST_OLD;
        end
      end

      ST_OLD: begin
        out_load = 1'b1;
        out_last = ((CNTW'(oidx_q) + CNTW'(1)) == count_q);
        if (out_last) begin
          count_d = '0;
          state_d = ST_LOAD;
        end else begin
          oidx_d  = oidx_q + IDXW'(1);
          state_d = ST_ORD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    k_q     <= k_d;
    m_q     <= m_d;
    oidx_q  <= oidx_d;
    pivot_q <= pivot_d;
    vk_q    <= vk_d;
    tmp_q   <= tmp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= elem_mem[mem_raddr];
    end
  end

  qse_range_stack #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW)
  ) u_range_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (stk_cmd),
    .push_lo_i (stk_push_lo),
    .push_hi_i (stk_push_hi),
    .pop_lo_o  (stk_pop_lo),
    .pop_hi_o  (stk_pop_hi),
    .empty_o   (stk_empty)
  );

  qse_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .value_i (rdata_q),
    .last_i  (out_last),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .value_o (sorted_value_o),
    .last_o  (last_res_o)
  );

  `QSE_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_CMP) |-> ((k_q <= hi_q) && (lo_q < hi_q) && (m_q < k_q)), "partition scan index outside its range")
  `QSE_ASSERT(a_load_stack_empty, clk_i, rst_ni, (state_q == ST_LOAD) |-> stk_empty, "range stack not empty while loading")

endmodule

`default_nettype wire

/* dv/qse_tb_pkg.sv */
`timescale 1ns / 100ps

package qse_tb_pkg;
  import qse_pkg::*;

  localparam int SORT_CAP = 16;

  typedef struct {
    value_t value;
    bit     last;
  } sorted_entry_t;

  // Tracks the set being loaded and the sorted values the engine still owes.
  class sort_scoreboard;
    value_t        held[SORT_CAP];
    int            held_count;
    int            span_lo[SORT_CAP+1];
    int            span_hi[SORT_CAP+1];
    int            span_depth;
    sorted_entry_t expected_q[$];
    int            sets_sorted;
    int            results_checked;

    function new();
      held_count      = 0;
      span_depth      = 0;
      sets_sorted     = 0;
      results_checked = 0;
    endfunction

    function void push_span(int lo, int hi);
      if (lo < hi && span_depth < SORT_CAP + 1) begin
        span_lo[span_depth] = lo;
        span_hi[span_depth] = hi;
        span_depth++;
      end
    endfunction

    // Lomuto split with the first element of the range as the pivot.
    function int split_at_pivot(int lo, int hi);
      value_t pivot;
      value_t tmp;
      int     m;
      pivot = held[lo];
      m     = lo;
      for (int k = lo + 1; k <= hi; k++) begin
        if (held[k] < pivot) begin
          m++;
          tmp     = held[k];
          held[k] = held[m];
          held[m] = tmp;
        end
      end
      tmp      = held[m];
      held[m]  = held[lo];
      held[lo] = tmp;
      return m;
    endfunction

    function void sort_held();
      int lo;
      int hi;
      int mid;
      span_depth = 0;
      push_span(0, held_count - 1);
      while (span_depth > 0) begin
        span_depth--;
        lo  = span_lo[span_depth];
        hi  = span_hi[span_depth];
        mid = split_at_pivot(lo, hi);
        push_span(mid + 1, hi);
        push_span(lo, mid - 1);
      end
    endfunction

    function void note_element(value_t v, logic lst);
      sorted_entry_t e;
      if (held_count < SORT_CAP) begin
        held[held_count] = v;
        held_count++;
      end
      if (lst) begin
        sort_held();
        for (int i = 0; i < held_count; i++) begin
          e.value = held[i];
          e.last  = (i + 1 == held_count);
          expected_q.push_back(e);
        end
        held_count = 0;
        sets_sorted++;
      end
    endfunction

    // Returns an empty string when the result matches, else a description.
    function string check_result(value_t v, logic lst);
      sorted_entry_t e;
      string         msg;
      if (expected_q.size() == 0)
        return $sformatf("result with nothing pending: value=%0d last=%0b", v, lst);
      e = expected_q.pop_front();
      results_checked++;
      msg = "";
      if (v !== e.value)
        msg = {msg, $sformatf(" sorted_value=%0d expected %0d", v, e.value)};
      if (lst !== e.last)
        msg = {msg, $sformatf(" last_res=%0b expected %0b", lst, e.last)};
      if (msg != "")
        msg = $sformatf("result %0d:%s", results_checked, msg);
      return msg;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import qse_pkg::*;
  import qse_tb_pkg::*;

  // Minimum number of random elements to transfer after the directed sets.
  localparam int RANDOM_ITEMS = 330;
  // Cycles to keep watching the output after the last expected result.
  localparam int TAIL_CYCLES  = 600;

  localparam value_t VAL_MAX = value_t'(32'h7fff_ffff);
  localparam value_t VAL_MIN = value_t'(32'h8000_0000);

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  value_t value_i     = '0;
  logic   last_i      = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  value_t sorted_value_o;
  logic   last_res_o;

  sort_scoreboard sb = new();

  int mismatches     = 0;
  int items_sent     = 0;
  int overflow_sets  = 0;
  int drain_pauses   = 0;
  int burst_left     = 0;
  bit steady         = 1'b0;

  quick_sort_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_res_o     (last_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Every mismatch goes through here so the verdict only has to look at one counter.
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Both channels are sampled at the rising edge, before the nonblocking updates
  // of that edge land, so each transfer is seen exactly once with its own payload.
  always @(posedge clk_i) begin : monitor
    string msg;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_element(value_i, last_i);
      if (out_valid_o && out_ready_i) begin
        msg = sb.check_result(sorted_value_o, last_res_o);
        if (msg != "")
          report_mismatch(msg);
      end
    end
  end

  // The receiver cycles through stall patterns of its own: always ready, mostly
  // ready, mostly stalled, and a fixed one-in-eight window. Each pattern holds for
  // a random stretch so gaps land on every phase of the result stream.
  int ready_mode  = 0;
  int mode_left   = 0;
  int ready_phase = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end
    mode_left--;
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ready_i <= (ready_phase == 0);
        ready_phase = (ready_phase + 1) % 8;
      end
    endcase
  end

  // Presents one element and holds it until the transfer happens. The sender works
  // in bursts; between bursts valid drops for a random gap, unless the current set
  // is marked steady, in which case elements go back to back.
  task automatic send_item(value_t v, bit lst);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
  endtask

  // Sends a whole set with last on its final element. Sets longer than the
  // capacity exercise the drop path, including a last that is itself dropped.
  task automatic send_set(value_t vals[$]);
    if (vals.size() > SORT_CAP)
      overflow_sets++;
    foreach (vals[i])
      send_item(vals[i], i == vals.size() - 1);
  endtask

  // Holds the sender off until every sorted value owed has come out. The first
  // edge lets the monitor record the transfer that just completed.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    drain_pauses++;
  endtask

  initial begin : stimulus
    value_t vals[$];
    value_t base;
    int     len;
    int     mode;
    int     step;
    int     pick;
    int     random_items;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A single element must come back alone with last set.
    vals = {VAL_MIN};
    send_set(vals);
    // Both extremes, zero, plus and minus one, and a repeated value.
    vals = {VAL_MAX, VAL_MIN, value_t'(-1), value_t'(0), value_t'(1), VAL_MAX};
    send_set(vals);
    // Descending run past capacity: two values are dropped, the last of them
    // carrying the marker that starts the sort of the sixteen held values.
    vals = {};
    for (int i = 0; i < SORT_CAP + 2; i++)
      vals.push_back(value_t'(SORT_CAP + 1 - i));
    send_set(vals);
    wait_drained();

    // Random part: whole sets with random lengths and content patterns. Sorted and
    // reverse-sorted sets drive the pivot choice into its deepest recursion, and
    // narrow ranges force many equal values.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick < 2)
        len = $urandom_range(SORT_CAP + 1, SORT_CAP + 4);
      else if (pick < 4)
        len = 1;
      else
        len = $urandom_range(2, SORT_CAP);
      mode   = $urandom_range(0, 6);
      base   = value_t'($urandom);
      step   = $urandom_range(0, 1000);
      steady = ($urandom_range(0, 3) == 0);
      if (mode == 2 || mode == 3)
        base = value_t'($urandom_range(0, 2000)) - value_t'(1000);
      vals = {};
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: vals.push_back(value_t'($urandom));
          1: vals.push_back(value_t'($urandom_range(0, 8)) - value_t'(4));
          2: vals.push_back(base + value_t'(i * step));
          3: vals.push_back(base - value_t'(i * step));
          4: vals.push_back(base);
          5: begin
            case ($urandom_range(0, 4))
              0: vals.push_back(VAL_MIN);
              1: vals.push_back(VAL_MAX);
              2: vals.push_back(value_t'(0));
              3: vals.push_back(value_t'(-1));
              default: vals.push_back(value_t'(1));
            endcase
          end
          default: vals.push_back(value_t'({$urandom_range(0, 1) ? 16'hffff : 16'h0000,
                                            16'($urandom)}));
        endcase
      end
      send_set(vals);
      random_items += len;
      if ($urandom_range(0, 7) == 0)
        wait_drained();
    end
    in_valid_i <= 1'b0;

    // Let everything owed come out, then watch a while longer for strays.
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sorted %0d sets from %0d elements (%0d over capacity), checked %0d values.",
             sb.sets_sorted, items_sent, overflow_sets, sb.results_checked);
    $display("Sender paused for a full drain %0d times; %0d mismatches.",
             drain_pauses, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Worst-case runs take well under a millisecond; this only catches a hang.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d sorted values still pending.", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/qse_pkg.sv
rtl/qse_range_stack.sv
rtl/qse_out_stage.sv
rtl/quick_sort_engine.sv
dv/qse_tb_pkg.sv
dv/tb.sv
